### rtl/sdp_pkg.sv
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types and constants of the straight drive pid controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sdp_pkg;

  localparam int MS_PER_S = 1000;

  // register indexes
  localparam logic [2:0] REG_KP_SPEED = 3'd0;
  localparam logic [2:0] REG_KI_SPEED = 3'd1;
  localparam logic [2:0] REG_KD_SPEED = 3'd2;
  localparam logic [2:0] REG_KP_TURN  = 3'd3;
  localparam logic [2:0] REG_KI_TURN  = 3'd4;
  localparam logic [2:0] REG_KD_TURN  = 3'd5;
  localparam logic [2:0] REG_WHEEL    = 3'd6;

  // micro operations of the sequencer
  localparam logic [3:0] OP_S_INT   = 4'd0;
  localparam logic [3:0] OP_S_SLOPE = 4'd1;
  localparam logic [3:0] OP_T_INT   = 4'd2;
  localparam logic [3:0] OP_T_SLOPE = 4'd3;
  localparam logic [3:0] OP_DIST    = 4'd4;
  localparam logic [3:0] OP_KP_S    = 4'd5;
  localparam logic [3:0] OP_KI_S    = 4'd6;
  localparam logic [3:0] OP_KD_S    = 4'd7;
  localparam logic [3:0] OP_KP_T    = 4'd8;
  localparam logic [3:0] OP_KI_T    = 4'd9;
  localparam logic [3:0] OP_KD_T    = 4'd10;
  localparam logic [3:0] OP_MIX     = 4'd11;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_DIVS  = 7'b0001000,
    S_DIVW  = 7'b0010000,
    S_ACC   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'sh0_0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -68'sh0_0000_0000_8000_0000) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/sdp_if.sv
// ----------------------------------------------------------------------------
// sdp_cmd_if / sdp_rsp_if
// Valid/ready channels for control ticks and drive results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdp_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_distance;
  logic signed [31:0] speed_goal;
  logic        [31:0] time_ms;
  logic signed [31:0] measured_speed;
  logic signed [31:0] measured_turn_rate;
  modport source (output valid, target_distance, speed_goal, time_ms,
                  measured_speed, measured_turn_rate, input ready);
  modport sink (input valid, target_distance, speed_goal, time_ms,
                measured_speed, measured_turn_rate, output ready);
endinterface

interface sdp_rsp_if;
  logic               valid;
  logic               ready;
  logic               drive_valid;
  logic               direction;
  logic        [9:0]  left_drive;
  logic        [9:0]  right_drive;
  logic signed [31:0] remaining_distance;
  modport source (output valid, drive_valid, direction, left_drive, right_drive,
                  remaining_distance, input ready);
  modport sink (input valid, drive_valid, direction, left_drive, right_drive,
                remaining_distance, output ready);
endinterface

`default_nettype wire

### rtl/sdp_div.sv
// ----------------------------------------------------------------------------
// sdp_div / sdp_div1000
// Radix-2 restoring divider, signed dividend, unsigned divisor, one quotient
// bit per cycle, and a divide by one thousand by reciprocal multiplication,
// 16 dividend bits per estimate and correction step; both truncate toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_div #(
  parameter int NW = 66,
  parameter int DW = 32
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire signed [NW-1:0]  num,
  input  wire        [DW-1:0]  den,
  output logic                 done,
  output logic signed [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] mag;
  logic [DW-1:0] rem;
  logic [DW-1:0] dv;
  logic          neg;
  logic [DW:0]   sh;
  logic          qb;

  always_comb begin
    sh = {rem, mag[NW-1]};
    qb = (sh >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NW-1];
      mag <= num[NW-1] ? NW'(-num) : NW'(num);
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      rem <= qb ? DW'(sh - {1'b0, dv}) : sh[DW-1:0];
      mag <= {mag[NW-2:0], qb};
    end
  end

  assign quo = neg ? -$signed(mag) : $signed(mag);

endmodule

module sdp_div1000 (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire signed [65:0]  num,
  output logic               done,
  output logic signed [65:0] quo
);

  // ceil(2^36 / 1000), exact for partial dividends below 1000 * 2^16
  localparam logic [26:0] RECIP   = 27'd68719477;
  localparam logic [9:0]  DIVISOR = 10'd1000;

  logic        busy;
  logic        step;
  logic [1:0]  cnt;
  logic [63:0] mag;
  logic [63:0] q;
  logic [9:0]  rem;
  logic [15:0] qc;
  logic        neg;
  logic [25:0] cur;
  logic [52:0] est;

  always_comb begin
    cur = {rem, mag[63:48]};
    est = cur * RECIP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 1'b0;
        cnt  <= 2'd3;
      end else if (busy) begin
        step <= !step;
        if (step) begin
          cnt <= cnt - 2'd1;
          if (cnt == 2'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[65];
      mag <= 64'(num[65] ? -num : num);
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      if (!step) begin
        qc <= 16'(est >> 36);
      end else begin
        rem <= 10'(cur - 26'(qc) * 26'(DIVISOR));
        q   <= {q[47:0], qc};
        mag <= {mag[47:0], 16'd0};
      end
    end
  end

  assign quo = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});

endmodule

`default_nettype wire

### rtl/straight_drive_pid_controller.sv
// ----------------------------------------------------------------------------
// straight_drive_pid_controller
// Speed and zero-turn pid loops with wheel mixing and distance integration.
// ----------------------------------------------------------------------------
// One control tick is taken at a time. The two slope divisions by the elapsed
// time go through one shared restoring divider at one quotient bit per cycle,
// the three divisions by one thousand go through a reciprocal unit at 16 bits
// per estimate and correction step, and all products go through one shared
// 33x33 multiplier, one product per step of the sequencer. A new tick is taken
// while the previous result still waits at the output register; the next
// result then waits in the last state until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module straight_drive_pid_controller #(
  parameter int FRAC_BITS = 16,
  parameter int DRIVE_MAX = 1000
) (
  input  wire        clk,
  input  wire        rst,
  sdp_cmd_if.sink    cmd,
  sdp_rsp_if.source  rsp,
  input  wire        cfg_we,
  input  wire [2:0]  cfg_index,
  input  wire [31:0] cfg_data
);

  import sdp_pkg::*;

  localparam int QONE = 1 << FRAC_BITS;
  localparam logic [32:0] RESTART_TOL = 33'((QONE + 50) / 100);
  localparam logic [31:0] KP_SPEED_RST = 32'(1000 * QONE);
  localparam logic [31:0] KP_TURN_RST = 32'((QONE + 5) / 10);
  localparam logic [31:0] WHEEL_RST = 32'((65 * QONE + 500) / 1000);
  localparam logic signed [67:0] DRIVE_LIM = 68'(DRIVE_MAX) <<< FRAC_BITS;

  logic [31:0] kp_speed, ki_speed, kd_speed, kp_turn, ki_turn, kd_turn, mix_length;

  state_t state;
  logic [3:0] op;

  logic               started;
  logic signed [31:0] goal_magnitude, distance_left;
  logic        [31:0] previous_time;
  logic signed [31:0] speed_error, speed_integral, speed_slope;
  logic signed [31:0] turn_error, turn_integral, turn_slope;

  logic signed [31:0] goal_dist, tspeed, vmeas_in, wmeas;
  logic        [31:0] now;
  logic signed [31:0] es, et, vm;
  logic        [31:0] dt;
  logic signed [31:0] v, w;
  logic signed [67:0] acc;
  logic signed [65:0] prod;

  logic               res_dv, res_dir;
  logic        [9:0]  res_l, res_r;
  logic signed [31:0] res_rem;

  // tick checks
  logic               back;
  logic signed [32:0] mag33, diff;
  logic signed [31:0] mag;
  logic        [32:0] adiff;
  logic               restart;
  logic signed [31:0] vm_eff;

  always_comb begin
    back    = goal_dist[31];
    mag33   = back ? -33'(goal_dist) : 33'(goal_dist);
    mag     = sat32(68'(mag33));
    diff    = 33'(mag) - 33'(goal_magnitude);
    adiff   = diff[32] ? 33'(-diff) : 33'(diff);
    restart = !started || (adiff > RESTART_TOL);
    vm_eff  = back ? sat32(-68'(vmeas_in)) : vmeas_in;
  end

  // shared multiplier operands
  logic signed [32:0] opa, opb;
  always_comb begin
    opa = '0;
    opb = '0;
    case (op)
      OP_S_INT:   begin opa = 33'(es); opb = $signed({1'b0, dt}); end
      OP_S_SLOPE: begin opa = 33'(es) - 33'(speed_error); opb = 33'(MS_PER_S); end
      OP_T_INT:   begin opa = 33'(et); opb = $signed({1'b0, dt}); end
      OP_T_SLOPE: begin opa = 33'(et) - 33'(turn_error); opb = 33'(MS_PER_S); end
      OP_DIST:    begin opa = 33'(vm); opb = $signed({1'b0, dt}); end
      OP_KP_S:    begin opa = $signed({1'b0, kp_speed}); opb = 33'(speed_error); end
      OP_KI_S:    begin opa = $signed({1'b0, ki_speed}); opb = 33'(speed_integral); end
      OP_KD_S:    begin opa = $signed({1'b0, kd_speed}); opb = 33'(speed_slope); end
      OP_KP_T:    begin opa = $signed({1'b0, kp_turn}); opb = 33'(turn_error); end
      OP_KI_T:    begin opa = $signed({1'b0, ki_turn}); opb = 33'(turn_integral); end
      OP_KD_T:    begin opa = $signed({1'b0, kd_turn}); opb = 33'(turn_slope); end
      OP_MIX:     begin opa = 33'(w); opb = $signed({1'b0, mix_length}); end
      default:    begin opa = '0; opb = '0; end
    endcase
  end

  // division by elapsed time and by one thousand
  logic               by_dt;
  logic               div_start, div_done, rcp_start, rcp_done, quo_done;
  logic signed [65:0] div_quo, rcp_quo, quo;

  assign by_dt     = (op == OP_S_SLOPE || op == OP_T_SLOPE);
  assign div_start = (state == S_DIVS) && by_dt;
  assign rcp_start = (state == S_DIVS) && !by_dt;
  assign quo_done  = by_dt ? div_done : rcp_done;
  assign quo       = by_dt ? div_quo : rcp_quo;

  sdp_div #(.NW(66), .DW(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod), .den(dt),
    .done(div_done), .quo(div_quo)
  );

  sdp_div1000 u_rcp (
    .clk(clk), .rst(rst), .start(rcp_start), .num(prod),
    .done(rcp_done), .quo(rcp_quo)
  );

  function automatic logic [9:0] drive_level(input logic signed [67:0] x);
    logic [9:0] r;
    if (x <= 0) r = '0;
    else if (x >= DRIVE_LIM) r = 10'(DRIVE_MAX);
    else r = 10'(x >>> FRAC_BITS);
    return r;
  endfunction

  logic signed [65:0] fs, half;
  assign fs   = prod >>> FRAC_BITS;
  assign half = prod >>> (FRAC_BITS + 1);

  assign cmd.ready = (state == S_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_speed   <= KP_SPEED_RST;
      ki_speed   <= '0;
      kd_speed   <= '0;
      kp_turn    <= KP_TURN_RST;
      ki_turn    <= '0;
      kd_turn    <= '0;
      mix_length <= WHEEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_SPEED: kp_speed   <= cfg_data;
        REG_KI_SPEED: ki_speed   <= cfg_data;
        REG_KD_SPEED: kd_speed   <= cfg_data;
        REG_KP_TURN:  kp_turn    <= cfg_data;
        REG_KI_TURN:  ki_turn    <= cfg_data;
        REG_KD_TURN:  kd_turn    <= cfg_data;
        REG_WHEEL:    mix_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_S_INT;
      started        <= 1'b0;
      goal_magnitude <= '0;
      distance_left  <= '0;
      previous_time  <= '0;
      speed_error    <= '0;
      speed_integral <= '0;
      speed_slope    <= '0;
      turn_error     <= '0;
      turn_integral  <= '0;
      turn_slope     <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (state == S_FIN && (!rsp.valid || rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            goal_dist <= cmd.target_distance;
            tspeed    <= cmd.speed_goal;
            now       <= cmd.time_ms;
            vmeas_in  <= cmd.measured_speed;
            wmeas     <= cmd.measured_turn_rate;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_dir       <= back;
          previous_time <= now;
          if (restart) begin
            started        <= 1'b1;
            goal_magnitude <= mag;
            distance_left  <= mag;
            speed_error    <= '0;
            speed_integral <= '0;
            speed_slope    <= '0;
            turn_error     <= '0;
            turn_integral  <= '0;
            turn_slope     <= '0;
            res_dv         <= 1'b0;
            res_l          <= '0;
            res_r          <= '0;
            res_rem        <= mag;
            state          <= S_FIN;
          end else begin
            dt    <= now - previous_time;
            vm    <= vm_eff;
            es    <= sat32(68'(tspeed) - 68'(vm_eff));
            et    <= sat32(-68'(wmeas));
            op    <= (now == previous_time) ? OP_KP_S : OP_S_INT;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= opa * opb;
          state <= (op <= OP_DIST) ? S_DIVS : S_ACC;
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (quo_done) begin
            case (op)
              OP_S_INT: speed_integral <= sat32(68'(speed_integral) + 68'(quo));
              OP_S_SLOPE: begin
                speed_slope <= sat32(68'(quo));
                speed_error <= es;
              end
              OP_T_INT: turn_integral <= sat32(68'(turn_integral) + 68'(quo));
              OP_T_SLOPE: begin
                turn_slope <= sat32(68'(quo));
                turn_error <= et;
              end
              default: distance_left <= sat32(68'(distance_left) - 68'(quo));
            endcase
            op    <= op + 4'd1;
            state <= S_MUL;
          end
        end
        S_ACC: begin
          op    <= op + 4'd1;
          state <= S_MUL;
          case (op) inside
            OP_KP_S, OP_KP_T: acc <= 68'(fs);
            OP_KD_S: v <= sat32(acc + 68'(fs));
            OP_KD_T: w <= sat32(acc + 68'(fs));
            OP_MIX: begin
              res_dv  <= 1'b1;
              res_l   <= drive_level(68'(v) - 68'(half));
              res_r   <= drive_level(68'(v) + 68'(half));
              res_rem <= distance_left;
              state   <= S_FIN;
            end
            default: acc <= acc + 68'(fs);
          endcase
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!rsp.valid || rsp.ready)) begin
      rsp.drive_valid        <= res_dv;
      rsp.direction          <= res_dir;
      rsp.left_drive         <= res_l;
      rsp.right_drive        <= res_r;
      rsp.remaining_distance <= res_rem;
    end
  end

endmodule

`default_nettype wire

### rtl/sdp_checker.sv
// ----------------------------------------------------------------------------
// sdp_checker
// Port level checks of the straight drive pid controller.
// ----------------------------------------------------------------------------
`default_nettype none

module sdp_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_rem
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_rem))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind straight_drive_pid_controller sdp_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(cmd.valid), .in_ready(cmd.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_rem(rsp.remaining_distance)
);

`default_nettype wire

### tb/straight_drive_pid_controller_tb.sv
// ----------------------------------------------------------------------------
// straight_drive_pid_controller_tb
// Drives control ticks through the speed and turn pid controller and checks
// every drive result against a cycle-free predictor of the same fixed point
// math. Runs a directed table, then random move sequences over several gain
// settings, with random idling on both channels and long output back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module straight_drive_pid_controller_tb;
  import sdp_pkg::*;

  typedef struct {
    int          goal;
    int          speed;
    logic [31:0] tm;
    int          vmeas;
    int          wmeas;
  } tick_t;

  typedef struct {
    bit          dv;
    bit          dir;
    logic [9:0]  left;
    logic [9:0]  right;
    int          rem;
  } drive_t;

  typedef struct {
    tick_t  tk;
    bit     typed;
    drive_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sdp_cmd_if cmd_if ();
  sdp_rsp_if rsp_if ();

  straight_drive_pid_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [31:0] gain [7];
  bit          started;
  int          goal_mag, dist_left;
  logic [31:0] prev_tm;
  int          s_err, s_int, s_slope, t_err, t_int, t_slope;

  drive_t pending_drives [$];
  int     errors = 0;
  bit     idle_en = 1'b1;
  bit     hold_req = 1'b0;
  int     hold_left = 0;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  function automatic logic [9:0] drive_level(longint x);
    if (x <= 0) return 10'd0;
    if (x >= 64'sd1000 * 65536) return 10'd1000;
    return x[25:16];
  endfunction

  task automatic pid_step(inout int err, inout int integ, inout int slope,
                          input longint target, input longint meas,
                          input logic [31:0] dt);
    longint e, prev;
    if (dt == 0) return;
    prev = err;
    e = sat32(target - meas);
    err = int'(e);
    integ = sat32(longint'(integ) + (e * longint'(dt)) / MS_PER_S);
    slope = sat32(((e - prev) * MS_PER_S) / longint'(dt));
  endtask

  function automatic int pid_sum(int err, int integ, int slope,
                                 logic [31:0] kp, logic [31:0] ki, logic [31:0] kd);
    longint acc;
    acc = ((longint'(kp) * err) >>> 16) + ((longint'(ki) * integ) >>> 16)
        + ((longint'(kd) * slope) >>> 16);
    return sat32(acc);
  endfunction

  task automatic predict_drive(input tick_t t, output drive_t r);
    longint mag, diff, vm, half;
    logic [31:0] dt;
    int v, w;
    bit back;
    back = t.goal < 0;
    mag = sat32(back ? -longint'(t.goal) : longint'(t.goal));
    diff = mag - goal_mag;
    if (diff < 0) diff = -diff;
    r.dir = back;
    if (!started || diff > 655) begin
      started = 1'b1;
      goal_mag = int'(mag);
      dist_left = int'(mag);
      prev_tm = t.tm;
      s_err = 0; s_int = 0; s_slope = 0;
      t_err = 0; t_int = 0; t_slope = 0;
      r.dv = 1'b0; r.left = '0; r.right = '0; r.rem = int'(mag);
      return;
    end
    dt = t.tm - prev_tm;
    prev_tm = t.tm;
    vm = t.vmeas;
    if (back) vm = sat32(-vm);
    pid_step(s_err, s_int, s_slope, t.speed, vm, dt);
    pid_step(t_err, t_int, t_slope, 0, t.wmeas, dt);
    v = pid_sum(s_err, s_int, s_slope, gain[REG_KP_SPEED], gain[REG_KI_SPEED],
                gain[REG_KD_SPEED]);
    w = pid_sum(t_err, t_int, t_slope, gain[REG_KP_TURN], gain[REG_KI_TURN],
                gain[REG_KD_TURN]);
    half = (longint'(w) * longint'(gain[REG_WHEEL])) >>> 17;
    dist_left = sat32(longint'(dist_left) - (vm * longint'(dt)) / MS_PER_S);
    r.dv = 1'b1;
    r.left = drive_level(longint'(v) - half);
    r.right = drive_level(longint'(v) + half);
    r.rem = dist_left;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_tick(input tick_t t, input bit typed, input drive_t typed_res);
    drive_t r;
    while (idle_en && $urandom_range(99) < 19) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.target_distance <= t.goal;
    cmd_if.speed_goal <= t.speed;
    cmd_if.time_ms <= t.tm;
    cmd_if.measured_speed <= t.vmeas;
    cmd_if.measured_turn_rate <= t.wmeas;
    do @(posedge clk); while (!cmd_if.ready);
    predict_drive(t, r);
    pending_drives.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic load_gains(input logic [31:0] g [7]);
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= g[i];
      gain[i] = g[i];
      @(negedge clk);
    end
    // unused index, must be ignored
    cfg_index <= 3'd7;
    cfg_data <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic int pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: return int'($urandom_range(2 * 65536)) - 65536;
      default: return int'($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  // result side
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp_if.ready <= !(idle_en && $urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin
    drive_t e;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_drives.size() == 0) begin
        $error("unexpected drive result");
        errors++;
      end else begin
        e = pending_drives.pop_front();
        if (rsp_if.drive_valid !== e.dv) begin
          $error("drive_valid exp %0d got %0d", e.dv, rsp_if.drive_valid);
          errors++;
        end
        if (rsp_if.direction !== e.dir) begin
          $error("direction exp %0d got %0d", e.dir, rsp_if.direction);
          errors++;
        end
        if (rsp_if.left_drive !== e.left) begin
          $error("left_drive exp %0d got %0d", e.left, rsp_if.left_drive);
          errors++;
        end
        if (rsp_if.right_drive !== e.right) begin
          $error("right_drive exp %0d got %0d", e.right, rsp_if.right_drive);
          errors++;
        end
        if (rsp_if.remaining_distance !== e.rem) begin
          $error("remaining_distance exp %0d got %0d", e.rem, rsp_if.remaining_distance);
          errors++;
        end
      end
    end
  end

  initial begin
    #(64'd80_000_000);
    $display("straight_drive_pid_controller test failed");
    $finish;
  end

  row_t rows [15] = '{
    '{'{327680, 65536, 32'd100, 0, 0}, 1, '{0, 0, 10'd0, 10'd0, 327680}},
    '{'{327680, 65536, 32'd100, 0, 0}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{327680, 65536, 32'd110, 0, 0}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{328335, 65536, 32'd120, 32768, 6554}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{328336, 0, 32'd130, 0, 0}, 1, '{0, 0, 10'd0, 10'd0, 328336}},
    '{'{32'sh8000_0000, 0, 32'd140, 0, 0}, 1, '{0, 1, 10'd0, 10'd0, 32'sh7FFF_FFFF}},
    '{'{-2147483647, 32'sh7FFF_FFFF, 32'd141, 32'sh8000_0000, 32'sh7FFF_FFFF}, 0,
      '{0, 0, 10'd0, 10'd0, 0}},
    '{'{-2147483647, 32'sh8000_0000, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000}, 0,
      '{0, 0, 10'd0, 10'd0, 0}},
    '{'{-2147483647, 0, 32'd5, 0, 0}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{0, 0, 32'd0, 0, 0}, 1, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{0, 65536, 32'd1000, -65536, 65536}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{0, -65536, 32'd1001, 65536, -65536}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{32'sh7FFF_FFFF, 0, 32'd2000, 0, 0}, 1, '{0, 0, 10'd0, 10'd0, 32'sh7FFF_FFFF}},
    '{'{32'sh7FFF_FFFF, 6553, 32'd2010, 0, 32'sh7FFF_0000}, 0, '{0, 0, 10'd0, 10'd0, 0}},
    '{'{32'sh7FFF_FFFF, 131072, 32'h8000_0000, 32'sh8000_0000, 0}, 0,
      '{0, 0, 10'd0, 10'd0, 0}}
  };

  initial begin
    logic [31:0] g [7];
    tick_t t;
    drive_t none;
    int base, len;
    logic [31:0] now;
    none = '{0, 0, 10'd0, 10'd0, 0};
    cmd_if.valid = 1'b0;
    cmd_if.target_distance = '0;
    cmd_if.speed_goal = '0;
    cmd_if.time_ms = '0;
    cmd_if.measured_speed = '0;
    cmd_if.measured_turn_rate = '0;
    rsp_if.ready = 1'b0;
    gain = '{32'd65536000, 32'd0, 32'd0, 32'd6554, 32'd0, 32'd0, 32'd4260};
    started = 1'b0; goal_mag = 0; dist_left = 0; prev_tm = '0;
    s_err = 0; s_int = 0; s_slope = 0; t_err = 0; t_int = 0; t_slope = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) send_tick(rows[i].tk, rows[i].typed, rows[i].res);
    drain();

    now = $urandom;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: g = '{32'd65536000, 32'd0, 32'd0, 32'd6554, 32'd0, 32'd0, 32'd4260};
        1: g = '{default: 32'd0};
        2: g = '{default: 32'hFFFF_FFFF};
        default: begin
          for (int i = 0; i < 7; i++)
            g[i] = (phase == 4) ? $urandom : $urandom_range(2000 * 65536);
        end
      endcase
      load_gains(g);
      idle_en = (phase != 5);
      if (phase == 3) hold_req = 1'b1;
      for (int n = 0; n < 310; ) begin
        if ($urandom_range(9) == 0) begin
          t = '{pick_value(), pick_value(), $urandom, pick_value(), pick_value()};
          send_tick(t, 1'b0, none);
          n++;
        end else begin
          base = pick_value();
          len = $urandom_range(2, 40);
          t.speed = int'($urandom_range(4 * 65536)) - 65536;
          for (int k = 0; k < len; k++) begin
            t.goal = base;
            if (k > 0 && $urandom_range(3) == 0)
              t.goal = base + int'($urandom_range(1400)) - 700;
            case ($urandom_range(19))
              0: now = $urandom;
              1, 2: now = now;
              default: now = now + $urandom_range(1, 20);
            endcase
            t.tm = now;
            t.vmeas = ($urandom_range(7) == 0) ? pick_value()
                    : t.speed + int'($urandom_range(32768)) - 16384;
            t.wmeas = ($urandom_range(7) == 0) ? pick_value()
                    : int'($urandom_range(65536)) - 32768;
            send_tick(t, 1'b0, none);
            n++;
          end
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("straight_drive_pid_controller test passed");
    end else begin
      $display("straight_drive_pid_controller test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
